FILE: sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Configuration register index width and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd1;

    // Reset values of the configuration registers.
    localparam int unsigned RESET_MODULUS  = 23;
    localparam int unsigned RESET_EXPONENT = 3;

    // Exponentiation sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_mexp_state;

endpackage

`default_nettype wire

FILE: sv/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Right-to-left square-and-multiply: base ^ exponent mod modulus, with the
// modulus and exponent held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_ready         i_base_value
//  result    out        o_valid / i_ready         o_power_result,
//                                                 o_zero_modulus_error
//  config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
//  Each modular product runs bit-serially on the shared multiplier.
//  A request reduces the base, then per exponent bit up to the highest set one
//  spends a check state, a multiply if the bit is set and a square if it is not
//  the highest, then loads the output; a zero modulus skips straight to the
//  output load. Reset is synchronous, active low; a result waiting in the
//  output register stalls only the next finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [OPERAND_WIDTH-1:0]        i_base_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [OPERAND_WIDTH-1:0]             o_power_result,
    output logic                                 o_zero_modulus_error,
    input  wire logic                            i_cfg_we,
    input  wire logic [mexp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [OPERAND_WIDTH-1:0]        i_cfg_data
);

    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    t_mexp_state  r_state, n_state;
    logic [W-1:0] r_modulus, n_modulus;
    logic [W-1:0] r_exponent, n_exponent;
    logic [W-1:0] r_exp, n_exp;
    logic [W-1:0] r_sq, n_sq;
    logic [W-1:0] r_res, n_res;
    logic         r_err, n_err;
    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_result, n_out_result;
    logic         r_out_err, n_out_err;

    logic         w_start;
    logic [W-1:0] w_op_a;
    logic [W-1:0] w_op_b;
    logic         w_mm_done;
    logic [W-1:0] w_mm_result;
    logic         w_accept;
    logic         w_more_bits;

    mexp_mulmod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .i_m     (r_modulus),
        .o_done  (w_mm_done),
        .o_result(w_mm_result)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    // Squaring is skipped once no higher exponent bit remains.
    assign w_more_bits = (r_exp[W-1:1] != '0);

    always_comb begin
        n_modulus  = r_modulus;
        n_exponent = r_exponent;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:  n_modulus  = i_cfg_data;
                REG_EXPONENT: n_exponent = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_exp        = r_exp;
        n_sq         = r_sq;
        n_res        = r_res;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_result = r_out_result;
        n_out_err    = r_out_err;
        w_start      = 1'b0;
        w_op_a       = r_sq;
        w_op_b       = r_sq;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_exp = r_exponent;
                    n_res = W'(1);
                    if (r_modulus == '0) begin
                        n_err   = 1'b1;
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        // Reduce the base as 1 * base mod m.
                        n_err   = 1'b0;
                        w_start = 1'b1;
                        w_op_a  = W'(1);
                        w_op_b  = i_base_value;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_result;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else if (r_exp[0]) begin
                    w_start = 1'b1;
                    w_op_a  = r_res;
                    n_state = ST_MUL;
                end else begin
                    w_start = 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (w_mm_done) begin
                    n_res = w_mm_result;
                    if (w_more_bits) begin
                        w_start = 1'b1;
                        n_state = ST_SQR;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SQR: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_result;
                    n_exp   = {1'b0, r_exp[W-1:1]};
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_result = r_res;
                    n_out_err    = r_err;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= W'(RESET_MODULUS);
            r_exponent  <= W'(RESET_EXPONENT);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_modulus   <= n_modulus;
            r_exponent  <= n_exponent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp        <= n_exp;
        r_sq         <= n_sq;
        r_res        <= n_res;
        r_err        <= n_err;
        r_out_result <= n_out_result;
        r_out_err    <= n_out_err;
    end

    assign o_valid              = r_out_valid;
    assign o_power_result       = r_out_result;
    assign o_zero_modulus_error = r_out_err;

endmodule

`default_nettype wire

FILE: sv/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m by shift-and-add, one bit of b
// per cycle starting at the most significant bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OPERAND_WIDTH-1:0] i_a,
    input  wire logic [OPERAND_WIDTH-1:0] i_b,
    input  wire logic [OPERAND_WIDTH-1:0] i_m,
    output logic                          o_done,
    output logic [OPERAND_WIDTH-1:0]      o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_acc,  n_acc;
    logic [W-1:0]  r_a,    n_a;
    logic [W-1:0]  r_b,    n_b;
    logic [W-1:0]  r_m,    n_m;
    logic [W-1:0]  w_dbl;

    // (x + y) mod m for x, y below m; also gives 0 for 1 mod 1.
    function automatic logic [W-1:0] add_mod(
        input logic [W-1:0] x,
        input logic [W-1:0] y,
        input logic [W-1:0] m
    );
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        w_dbl  = add_mod(r_acc, r_acc, r_m);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_BIT;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            n_acc = r_b[W-1] ? add_mod(w_dbl, r_a, r_m) : w_dbl;
            n_b   = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

FILE: sim/mexp_result_checker.sv
// ----------------------------------------------------------------------------
// mexp_result_checker
// Watches the request, result and register write ports of the modular
// exponentiation unit, predicts each result and compares it on arrival.
// ----------------------------------------------------------------------------
module mexp_result_checker #(
    parameter int W = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [W-1:0]                     i_base_value,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [W-1:0]                     i_power_result,
    input  logic                             i_zero_modulus_error,
    input  logic                             i_cfg_we,
    input  logic [mexp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [W-1:0]                     i_cfg_data,
    output int                               o_mismatch_count,
    output int                               o_outstanding
);

    import mexp_pkg::*;

    typedef struct packed {
        logic [W-1:0] power;
        logic         zero_mod;
    } t_power_result;

    logic [W-1:0]  modulus_reg;
    logic [W-1:0]  exponent_reg;
    t_power_result expected_q[$];
    t_power_result got;
    t_power_result want;
    int            mismatches = 0;

    // Square-and-multiply with exact double-width products.
    function automatic t_power_result power_mod(input logic [W-1:0] base,
                                                input logic [W-1:0] modv,
                                                input logic [W-1:0] expv);
        t_power_result  r;
        logic [2*W-1:0] sq;
        logic [2*W-1:0] acc;
        logic [W-1:0]   e;
        r.zero_mod = (modv == '0);
        r.power    = '0;
        if (r.zero_mod) begin
            return r;
        end
        sq  = base % modv;
        acc = 1;    // A zero exponent leaves this unreduced, even for a modulus of one.
        e   = expv;
        while (e != '0) begin
            if (e[0]) begin
                acc = (acc * sq) % modv;
            end
            sq = (sq * sq) % modv;
            e  = e >> 1;
        end
        r.power = acc[W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_reg  = W'(RESET_MODULUS);
            exponent_reg = W'(RESET_EXPONENT);
            expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = '{i_power_result, i_zero_modulus_error};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result power_result %h zero_modulus_error %b",
                                 $time, got.power, got.zero_mod);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.power !== want.power || got.zero_mod !== want.zero_mod) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch power_result expected %h got %h, ",
                                      "zero_modulus_error expected %b got %b"},
                                     $time, want.power, got.power, want.zero_mod,
                                     got.zero_mod);
                        end
                    end
                end
            end
            // A request is predicted with the registers as they stood before this edge.
            if (i_req_valid && i_req_ready) begin
                expected_q.push_back(power_mod(i_base_value, modulus_reg, exponent_reg));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODULUS:  modulus_reg = i_cfg_data;
                    REG_EXPONENT: exponent_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding    <= expected_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

FILE: sim/modular_exponentiation_unit_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_tb
// Drives directed and random requests through the modular exponentiation
// unit under several modulus and exponent settings, with bursty requests and
// a stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    localparam int W            = 32;
    localparam int RANDOM_ITEMS = 261;
    localparam int TAIL_CYCLES  = 2500;
    localparam int CYCLE_LIMIT  = 10_000_000;

    // Indexes past the two registers; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   base_valid   = 1'b0;
    logic                   base_ready;
    logic [W-1:0]           base_value   = '0;
    logic                   power_valid;
    logic                   power_ready  = 1'b0;
    logic [W-1:0]           power_result;
    logic                   zero_mod_err;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = REG_MODULUS;
    logic [W-1:0]           cfg_data     = '0;

    int mismatch_count;
    int outstanding;
    int sent_count = 0;
    int burst_left = 0;
    int ready_run  = 0;
    int cycles     = 0;

    modular_exponentiation_unit #(
        .OPERAND_WIDTH(W)
    ) uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (base_valid),
        .o_ready             (base_ready),
        .i_base_value        (base_value),
        .o_valid             (power_valid),
        .i_ready             (power_ready),
        .o_power_result      (power_result),
        .o_zero_modulus_error(zero_mod_err),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    mexp_result_checker #(
        .W(W)
    ) checker_i (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_req_valid         (base_valid),
        .i_req_ready         (base_ready),
        .i_base_value        (base_value),
        .i_res_valid         (power_valid),
        .i_res_ready         (power_ready),
        .i_power_result      (power_result),
        .i_zero_modulus_error(zero_mod_err),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_mismatch_count    (mismatch_count),
        .o_outstanding       (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: alternating ready and stall runs, some stalls long enough to
    // hold a finished result while the unit works on the next request.
    always @(posedge clk) begin
        if (ready_run == 0) begin
            if (power_ready) begin
                power_ready <= 1'b0;
                ready_run   <= ($urandom_range(0, 4) == 0) ? $urandom_range(300, 3000)
                                                           : $urandom_range(1, 20);
            end else begin
                power_ready <= 1'b1;
                ready_run   <= ($urandom_range(0, 5) == 0) ? $urandom_range(2000, 20000)
                                                           : $urandom_range(1, 600);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Random value whose highest set bit is bit width-1.
    function automatic logic [W-1:0] rand_bits(input int width);
        logic [W-1:0] v;
        v = '0;
        if (width > 0) begin
            v = W'($urandom) >> (W - width);
            v[width-1] = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [W-1:0] pick_base(input logic [W-1:0] modv);
        logic [W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = modv - 1;
            2: v = modv;
            3: v = modv + 1;
            4: if (modv != '0) v = v % modv;
            5: v = v >> $urandom_range(1, W - 1);
            default: ;
        endcase
        return v;
    endfunction

    // One request; valid stays high across a burst and drops only for a gap.
    task automatic send_base(input logic [W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 3000)
                                              : $urandom_range(0, 3);
            if (gap > 0) begin
                base_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        base_valid <= 1'b1;
        base_value <= value;
        @(posedge clk);
        while (!base_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_drained;
        base_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic load_config(input logic [W-1:0] modv, input logic [W-1:0] expv);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_data  <= modv;
        @(posedge clk);
        cfg_index <= REG_EXPONENT;
        cfg_data  <= expv;
        @(posedge clk);
        cfg_index <= $urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [W-1:0] modv;
        logic [W-1:0] expv;
        int           phase_len;
        int           random_start;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values.
        send_base('0);
        send_base(32'd1);
        send_base(32'd22);
        send_base(32'd23);
        send_base(32'd24);
        send_base(32'hFFFF_FFFF);
        send_base(32'hAAAA_AAAA);

        // Zero modulus flags an error for any exponent.
        wait_drained();
        load_config('0, 32'd3);
        send_base(32'd5);
        send_base(32'hFFFF_FFFF);
        wait_drained();
        load_config('0, '0);
        send_base(32'd7);

        // A zero exponent gives one even where the modulus is one.
        wait_drained();
        load_config(32'd1, '0);
        send_base('0);
        wait_drained();
        load_config(32'd1, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFF);

        // Large moduli, starting with the largest modulus and exponent: products need the full double width.
        wait_drained();
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        send_base(32'd2);
        wait_drained();
        load_config(32'hFFFF_FFFB, 32'hFFFF_FFFA);
        send_base(32'h5555_5555);
        send_base(32'h8000_0001);
        wait_drained();
        load_config(32'h8000_0000, 32'd2);
        send_base(32'hFFFF_FFFF);
        send_base(32'h8000_0001);

        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: modv = '0;
                1: modv = 32'd1;
                2: modv = 32'd2;
                3: modv = 32'hFFFF_FFFF;
                default: modv = rand_bits($urandom_range(2, W));
            endcase
            // Full-width exponents are slow, so most phases use short ones.
            case ($urandom_range(0, 7))
                0: expv = '0;
                1: expv = 32'hFFFF_FFFF;
                2: expv = $urandom;
                default: expv = rand_bits($urandom_range(1, 10));
            endcase
            wait_drained();
            load_config(modv, expv);
            phase_len = $urandom_range(5, 30);
            if (phase_len > RANDOM_ITEMS - (sent_count - random_start)) begin
                phase_len = RANDOM_ITEMS - (sent_count - random_start);
            end
            repeat (phase_len) send_base(pick_base(modv));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
